// File: rtl/core/itrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itrs_pkg;

  // default sizes
  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS_DEF = 32;

  // field widths
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 5;
  localparam int CHAR_W  = 7;

  // quotient bits resolved per divider cycle
  localparam int STEP_BITS = 4;

  // radix register
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd32;
  localparam logic [RADIX_W-1:0] SIGNED_BASE = 6'd10;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd65;
  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_NONE   = 7'd0;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 5'd10;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BAD,
    ST_DIVIDE,
    ST_SIGN,
    ST_FETCH,
    ST_EMIT
  } state_t;

  // digit value to ascii
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d >= DIGIT_TEN) begin
      ch = CHAR_LETTER + CHAR_W'(d - DIGIT_TEN);
    end else begin
      ch = CHAR_ZERO + CHAR_W'(d);
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/itrs_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module itrs_divider #(
  parameter int WORK_BITS = itrs_pkg::VALUE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [WORK_BITS-1:0]            dividend,
  input  wire logic [itrs_pkg::RADIX_W-1:0]    divisor,
  output logic                                 done,
  output logic [WORK_BITS-1:0]                 quotient,
  output logic [itrs_pkg::DIGIT_W-1:0]         remainder
);

  localparam int NSTEPS = WORK_BITS / itrs_pkg::STEP_BITS;
  localparam int CNT_W  = $clog2(NSTEPS + 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [WORK_BITS-1:0]          acc;
  logic [itrs_pkg::DIGIT_W-1:0]  rem;
  logic [WORK_BITS-1:0]          acc_next;
  logic [itrs_pkg::DIGIT_W-1:0]  rem_next;

  // restoring division, a few quotient bits per cycle
  always_comb begin
    logic [itrs_pkg::RADIX_W-1:0] t;
    logic [WORK_BITS-1:0]         q;
    logic [itrs_pkg::DIGIT_W-1:0] r;
    q = acc;
    r = rem;
    for (int k = 0; k < itrs_pkg::STEP_BITS; k++) begin
      t = {r, q[WORK_BITS-1]};
      q = {q[WORK_BITS-2:0], 1'b0};
      if (t >= divisor) begin
        t    = t - divisor;
        q[0] = 1'b1;
      end
      r = t[itrs_pkg::DIGIT_W-1:0];
    end
    acc_next = q;
    rem_next = r;
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NSTEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign quotient  = acc;
  assign remainder = rem;

`ifndef SYNTH
  // done pulses once, right after the last step
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a finished run");

  // remainder is always below the divisor once a run ends
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    done && (divisor != '0) |-> itrs_pkg::RADIX_W'(remainder) < divisor)
    else $error("divider remainder out of range");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("divider done held for two cycles");
`endif

endmodule

`default_nettype wire

// File: rtl/core/integer_to_radix_string_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Converts one signed VALUE_BITS-bit number into ASCII characters in the base held in the
// radix register (2..32), most significant digit first, one character per output word;
// last_char marks the final word. A leading '-' is sent only for negative values in base
// 10, other bases convert the absolute value. A radix outside 2..32 gives one word with
// character 0, last_char and bad_base set. Digits come from one shared iterative divider
// that resolves four quotient bits per cycle; digits are then read back from a small digit
// memory through a fetch and an emit step per character, after a sign step. in_ready is
// high only while the block is idle; the last character may still wait in the output
// register while the next number is taken.
module integer_to_radix_string_core #(
  parameter int VALUE_BITS = itrs_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = itrs_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          radix_wr_en,
  input  wire logic [itrs_pkg::RADIX_W-1:0]  radix_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [VALUE_BITS-1:0]  number_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [itrs_pkg::CHAR_W-1:0]        character,
  output logic                               last_char,
  output logic                               bad_base
);

  localparam int STEP      = itrs_pkg::STEP_BITS;
  localparam int WORK_BITS = ((VALUE_BITS + STEP - 1) / STEP) * STEP;
  localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W    = $clog2(MAX_DIGITS);

  itrs_pkg::state_t state, state_next;

  logic [itrs_pkg::RADIX_W-1:0] radix;
  logic                         show_minus;
  logic [CNT_W-1:0]             count;
  logic [ADDR_W-1:0]            ptr;
  logic [itrs_pkg::DIGIT_W-1:0] digit_mem [MAX_DIGITS];
  logic [itrs_pkg::DIGIT_W-1:0] rd_data;

  logic                         in_fire;
  logic                         radix_bad;
  logic                         negative;
  logic [VALUE_BITS-1:0]        magnitude;
  logic [CNT_W-1:0]             limit;
  logic [CNT_W-1:0]             cnt_inc;
  logic [CNT_W-1:0]             cnt_dec;
  logic                         more_digits;
  logic                         slot_free;

  logic                         div_start;
  logic                         div_first;
  logic [WORK_BITS-1:0]         div_dividend;
  logic                         div_done;
  logic [WORK_BITS-1:0]         div_quotient;
  logic [itrs_pkg::DIGIT_W-1:0] div_remainder;

  logic                         mem_wr;
  logic                         ptr_load;
  logic                         ptr_dec;
  logic                         out_load;
  logic [itrs_pkg::CHAR_W-1:0]  load_char;
  logic                         load_last;
  logic                         load_bad;

  // input side
  assign in_fire   = in_valid && in_ready;
  assign radix_bad = (radix < itrs_pkg::RADIX_MIN) || (radix > itrs_pkg::RADIX_MAX);
  assign negative  = number_in[VALUE_BITS-1];
  assign magnitude = negative ? (~number_in + 1'b1) : number_in;

  // digit count bookkeeping
  assign limit       = show_minus ? CNT_W'(MAX_DIGITS - 1) : CNT_W'(MAX_DIGITS);
  assign cnt_inc     = count + CNT_W'(1);
  assign cnt_dec     = count - CNT_W'(1);
  assign more_digits = (|div_quotient) && (cnt_inc < limit);
  assign slot_free   = !out_valid || out_ready;

  assign div_dividend = div_first ? WORK_BITS'(magnitude) : div_quotient;

  itrs_divider #(
    .WORK_BITS (WORK_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (radix),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      itrs_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = radix_bad ? itrs_pkg::ST_BAD : itrs_pkg::ST_DIVIDE;
        end
      end
      itrs_pkg::ST_BAD: begin
        if (slot_free) state_next = itrs_pkg::ST_IDLE;
      end
      itrs_pkg::ST_DIVIDE: begin
        if (div_done && !more_digits) state_next = itrs_pkg::ST_SIGN;
      end
      itrs_pkg::ST_SIGN: begin
        if (!show_minus || slot_free) state_next = itrs_pkg::ST_FETCH;
      end
      itrs_pkg::ST_FETCH: begin
        state_next = itrs_pkg::ST_EMIT;
      end
      itrs_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_next = (ptr == '0) ? itrs_pkg::ST_IDLE : itrs_pkg::ST_FETCH;
        end
      end
      default: state_next = itrs_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_first = 1'b0;
    mem_wr    = 1'b0;
    ptr_load  = 1'b0;
    ptr_dec   = 1'b0;
    out_load  = 1'b0;
    load_char = itrs_pkg::CHAR_NONE;
    load_last = 1'b0;
    load_bad  = 1'b0;
    unique case (state)
      itrs_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        div_first = 1'b1;
        div_start = in_valid && !radix_bad;
      end
      itrs_pkg::ST_BAD: begin
        out_load  = slot_free;
        load_char = itrs_pkg::CHAR_NONE;
        load_last = 1'b1;
        load_bad  = 1'b1;
      end
      itrs_pkg::ST_DIVIDE: begin
        mem_wr    = div_done;
        div_start = div_done && more_digits;
      end
      itrs_pkg::ST_SIGN: begin
        out_load  = show_minus && slot_free;
        load_char = itrs_pkg::CHAR_MINUS;
        ptr_load  = !show_minus || slot_free;
      end
      itrs_pkg::ST_FETCH: begin
        // memory read of the current digit is in flight
      end
      itrs_pkg::ST_EMIT: begin
        out_load  = slot_free;
        load_char = itrs_pkg::digit_char(rd_data);
        load_last = (ptr == '0);
        ptr_dec   = slot_free && (ptr != '0);
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= itrs_pkg::ST_IDLE;
      radix     <= itrs_pkg::RADIX_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (radix_wr_en) begin
        radix <= radix_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per-number working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      show_minus <= negative && (radix == itrs_pkg::SIGNED_BASE);
      count      <= '0;
    end else if (mem_wr) begin
      count <= cnt_inc;
    end
    if (ptr_load) begin
      ptr <= cnt_dec[ADDR_W-1:0];
    end else if (ptr_dec) begin
      ptr <= ptr - ADDR_W'(1);
    end
  end

  // digit memory, least significant digit at entry 0
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      digit_mem[count[ADDR_W-1:0]] <= div_remainder;
    end
    rd_data <= digit_mem[ptr];
  end

  // output word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      character <= load_char;
      last_char <= load_last;
      bad_base  <= load_bad;
    end
  end

`ifndef SYNTH
  // a bad-base word is a single flagged zero
  a_bad_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_base |-> last_char && (character == itrs_pkg::CHAR_NONE))
    else $error("bad base word malformed");

  // digit writes stay inside the allowed length
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    mem_wr |-> count < limit)
    else $error("digit count past limit");

  // a new word is only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> slot_free)
    else $error("output word overwritten");

  // an accepted number always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("ready held after accept");
`endif

endmodule

`default_nettype wire
